@@ rtl/core/ffrc_pkg.sv @@
// shared types, codes and helpers of the fixed frame receiver checker
package ffrc_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  localparam int TEMP_W = 15;
  localparam int MAG_W = 14;
  localparam int CFG_IDX_W = 2;
  localparam int TDATA_W = 48;
  localparam int TUSER_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 2'd2;

  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] VERSION_RESET = 8'h01;
  localparam logic [7:0] FOOTER_RESET = 8'h55;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_FRAMING = 2'd1;
  localparam logic [1:0] ERR_VERSION = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM = 2'd3;

  localparam logic [7:0] CMD_TIME = 8'h01;
  localparam logic [7:0] CMD_TEMP = 8'h02;
  localparam logic [7:0] SIGN_POSITIVE = 8'hFF;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] version;
    logic [7:0] footer;
  } cfg_t;

  typedef struct packed {
    logic [7:0] header;
    logic [7:0] version;
    logic [7:0] command;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    logic [7:0] checksum;
    logic [7:0] footer;
  } frame_t;

  typedef struct packed {
    logic                     frame_ok;
    logic [1:0]               error_code;
    logic [7:0]               command_code;
    logic [7:0]               data_first;
    logic [7:0]               data_second;
    logic [7:0]               data_third;
    logic                     time_update;
    logic                     temp_update;
    logic signed [TEMP_W-1:0] temp_hundredths;
  } result_t;

  // byte mod 100 by two conditional subtractions
  function automatic logic [6:0] mod100(input logic [7:0] v);
    logic [7:0] r;
    begin
      if (v >= 8'd200) begin
        r = v - 8'd200;
      end else if (v >= 8'd100) begin
        r = v - 8'd100;
      end else begin
        r = v;
      end
      mod100 = r[6:0];
    end
  endfunction

endpackage

@@ rtl/core/fixed_frame_receiver_checker.sv @@
// top level of the fixed frame receiver checker: config registers and stream ports
//
// channel   | direction | payload
// s_axis    | in        | tdata[7:0] rx_byte
// m_axis    | out       | tuser frame flags, tdata command, data and temperature
// cfg       | in        | cfg_index register number, cfg_data value
//
// one byte accepted per cycle while s_tready is high; after the eighth byte of a frame
// a result leaves through the snapshot register and then the result register
// synchronous reset clears the byte position, the valid flags and the config
// registers to their defaults
// the input stalls only while both the snapshot and the result are held
module fixed_frame_receiver_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // rx_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // frame_ok, error_code[2:1], time_update, temp_update
  output logic [ffrc_pkg::TUSER_W-1:0]  m_tuser,
  // command_code, data_first, data_second, data_third, temp_hundredths, zero pad
  output logic [ffrc_pkg::TDATA_W-1:0]  m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  ffrc_pkg::cfg_t    cfg;
  ffrc_pkg::frame_t  frame;
  ffrc_pkg::result_t res;
  logic              frame_valid;
  logic              frame_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header <= ffrc_pkg::HEADER_RESET;
      cfg.version <= ffrc_pkg::VERSION_RESET;
      cfg.footer <= ffrc_pkg::FOOTER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ffrc_pkg::REG_HEADER:  cfg.header <= cfg_data;
        ffrc_pkg::REG_VERSION: cfg.version <= cfg_data;
        ffrc_pkg::REG_FOOTER:  cfg.footer <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ffrc_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  ffrc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res         (res)
  );

  assign m_tuser = {res.temp_update, res.time_update, res.error_code, res.frame_ok};
  assign m_tdata = {1'b0, res.temp_hundredths, res.data_third, res.data_second,
                    res.data_first, res.command_code};

endmodule

@@ rtl/core/ffrc_framer.sv @@
// byte position counter, frame store and registered frame snapshot
module ffrc_framer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  output logic                  frame_valid,
  input  logic                  frame_ready,
  output ffrc_pkg::frame_t      frame
);

  logic [ffrc_pkg::POS_W-1:0] byte_position;
  logic [7:0]                 frame_store [ffrc_pkg::FRAME_BYTES-1];
  logic                       in_xfer;
  logic                       last_byte;

  assign in_ready = !frame_valid || frame_ready;
  assign in_xfer = in_valid && in_ready;
  assign last_byte = (byte_position == ffrc_pkg::POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_valid <= 1'b0;
    end else begin
      if (frame_ready) begin
        frame_valid <= 1'b0;
      end
      if (in_xfer) begin
        byte_position <= last_byte ? '0 : byte_position + 1'b1;
        if (last_byte) begin
          frame_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !last_byte) begin
      frame_store[byte_position] <= in_byte;
    end
    if (in_xfer && last_byte) begin
      frame.header <= frame_store[0];
      frame.version <= frame_store[1];
      frame.command <= frame_store[2];
      frame.d1 <= frame_store[3];
      frame.d2 <= frame_store[4];
      frame.d3 <= frame_store[5];
      frame.checksum <= frame_store[6];
      frame.footer <= in_byte;
    end
  end

endmodule

@@ rtl/core/ffrc_checker.sv @@
// frame check, temperature conversion and result register
module ffrc_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  ffrc_pkg::cfg_t        cfg,
  input  logic                  frame_valid,
  output logic                  frame_ready,
  input  ffrc_pkg::frame_t      frame,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ffrc_pkg::result_t     res
);

  ffrc_pkg::result_t              res_next;
  logic [7:0]                     sum;
  logic [1:0]                     err;
  logic                           ok;
  logic [6:0]                     m1;
  logic [6:0]                     m2;
  logic [ffrc_pkg::MAG_W-1:0]     mag;
  logic signed [ffrc_pkg::TEMP_W-1:0] temp;

  assign frame_ready = !res_valid || res_ready;

  always_comb begin
    sum = frame.command + frame.d1 + frame.d2 + frame.d3;
    if (frame.header != cfg.header || frame.footer != cfg.footer) begin
      err = ffrc_pkg::ERR_FRAMING;
    end else if (frame.version != cfg.version) begin
      err = ffrc_pkg::ERR_VERSION;
    end else if (sum != frame.checksum) begin
      err = ffrc_pkg::ERR_CHECKSUM;
    end else begin
      err = ffrc_pkg::ERR_OK;
    end
    ok = (err == ffrc_pkg::ERR_OK);

    // tens-and-units magnitude: m1 * 100 + m2
    m1 = ffrc_pkg::mod100(frame.d1);
    m2 = ffrc_pkg::mod100(frame.d2);
    mag = (ffrc_pkg::MAG_W'(m1) << 6) + (ffrc_pkg::MAG_W'(m1) << 5)
        + (ffrc_pkg::MAG_W'(m1) << 2) + ffrc_pkg::MAG_W'(m2);
    if (frame.d3 == ffrc_pkg::SIGN_POSITIVE) begin
      temp = $signed({1'b0, mag});
    end else begin
      temp = -$signed({1'b0, mag});
    end

    res_next.frame_ok = ok;
    res_next.error_code = err;
    res_next.command_code = frame.command;
    res_next.data_first = frame.d1;
    res_next.data_second = frame.d2;
    res_next.data_third = frame.d3;
    res_next.time_update = ok && (frame.command == ffrc_pkg::CMD_TIME);
    res_next.temp_update = ok && (frame.command == ffrc_pkg::CMD_TEMP);
    res_next.temp_hundredths = res_next.temp_update ? temp : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (frame_ready) begin
      res_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ready && frame_valid) begin
      res <= res_next;
    end
  end

endmodule

@@ verif/ffrc_result_checker.sv @@
// result checker of the fixed frame receiver: predicts each frame verdict and compares results
module ffrc_result_checker
  import ffrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [TUSER_W-1:0]   m_tuser,
  input  logic [TDATA_W-1:0]   m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   error_count,
  output int                   pending_count
);

  cfg_t             frame_cfg;
  logic [POS_W-1:0] byte_pos;
  logic [7:0]       rx_store [FRAME_BYTES-1];
  result_t          awaited_results [$];
  result_t          want_r;
  result_t          got_r;

  function automatic result_t judge_frame(input logic [7:0] last_byte);
    result_t    r;
    logic [7:0] sum;
    int         mag;
    r = '0;
    r.command_code = rx_store[2];
    r.data_first = rx_store[3];
    r.data_second = rx_store[4];
    r.data_third = rx_store[5];
    sum = 8'(rx_store[2] + rx_store[3] + rx_store[4] + rx_store[5]);
    if (rx_store[0] != frame_cfg.header || last_byte != frame_cfg.footer) begin
      r.error_code = ERR_FRAMING;
    end else if (rx_store[1] != frame_cfg.version) begin
      r.error_code = ERR_VERSION;
    end else if (sum != rx_store[6]) begin
      r.error_code = ERR_CHECKSUM;
    end else begin
      r.error_code = ERR_OK;
    end
    r.frame_ok = (r.error_code == ERR_OK);
    r.time_update = r.frame_ok && (r.command_code == CMD_TIME);
    r.temp_update = r.frame_ok && (r.command_code == CMD_TEMP);
    if (r.temp_update) begin
      mag = (int'(r.data_first) % 100) * 100 + int'(r.data_second) % 100;
      if (r.data_third != SIGN_POSITIVE) begin
        mag = -mag;
      end
      r.temp_hundredths = TEMP_W'(mag);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_cfg = '{header: HEADER_RESET, version: VERSION_RESET, footer: FOOTER_RESET};
      byte_pos = '0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got_r.frame_ok = m_tuser[0];
        got_r.error_code = m_tuser[2:1];
        got_r.time_update = m_tuser[3];
        got_r.temp_update = m_tuser[4];
        got_r.command_code = m_tdata[7:0];
        got_r.data_first = m_tdata[15:8];
        got_r.data_second = m_tdata[23:16];
        got_r.data_third = m_tdata[31:24];
        got_r.temp_hundredths = m_tdata[46:32];
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none awaited, expected nothing, actual tuser %h tdata %h",
                   $time, m_tuser, m_tdata);
        end else begin
          want_r = awaited_results.pop_front();
          check_field("frame_ok", want_r.frame_ok, got_r.frame_ok);
          check_field("error_code", want_r.error_code, got_r.error_code);
          check_field("command_code", want_r.command_code, got_r.command_code);
          check_field("data_first", want_r.data_first, got_r.data_first);
          check_field("data_second", want_r.data_second, got_r.data_second);
          check_field("data_third", want_r.data_third, got_r.data_third);
          check_field("time_update", want_r.time_update, got_r.time_update);
          check_field("temp_update", want_r.temp_update, got_r.temp_update);
          check_field("temp_hundredths", int'(want_r.temp_hundredths),
                      int'(got_r.temp_hundredths));
          check_field("tdata pad", 0, int'(m_tdata[TDATA_W-1:47]));
        end
      end
      if (s_tvalid && s_tready) begin
        if (byte_pos == POS_LAST) begin
          awaited_results.push_back(judge_frame(s_tdata));
          byte_pos = '0;
        end else begin
          rx_store[byte_pos] = s_tdata;
          byte_pos++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEADER: frame_cfg.header = cfg_data;
          REG_VERSION: frame_cfg.version = cfg_data;
          REG_FOOTER: frame_cfg.footer = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

@@ verif/tb_fixed_frame_receiver_checker.sv @@
// testbench top of the fixed frame receiver checker: stimulus, idling and verdict
module tb_fixed_frame_receiver_checker;
  import ffrc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TUSER_W-1:0]   m_tuser;
  logic [TDATA_W-1:0]   m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER;
  logic [7:0]           cfg_data = 8'h00;

  int   error_count;
  int   pending_count;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   bytes_sent = 0;
  cfg_t live_cfg = '{header: HEADER_RESET, version: VERSION_RESET, footer: FOOTER_RESET};

  fixed_frame_receiver_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ffrc_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tuser       (m_tuser),
    .m_tdata       (m_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic logic [7:0] frame_sum(input logic [7:0] c, d1, d2, d3);
    return 8'(c + d1 + d2 + d3);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] h, v, c, d1, d2, d3, cs, f);
    send_byte(h);
    send_byte(v);
    send_byte(c);
    send_byte(d1);
    send_byte(d2);
    send_byte(d3);
    send_byte(cs);
    send_byte(f);
  endtask

  task automatic send_random_frame();
    logic [7:0] h, v, c, d1, d2, d3, cs, f;
    int         kind;
    kind = $urandom_range(99);
    case ($urandom_range(9))
      0, 1, 2, 3: c = CMD_TIME;
      4, 5, 6: c = CMD_TEMP;
      default: c = 8'($urandom);
    endcase
    d1 = 8'($urandom);
    d2 = 8'($urandom);
    d3 = 8'($urandom);
    if ($urandom_range(2) == 0) begin
      d3 = SIGN_POSITIVE;
    end
    // magnitude of zero, so the sign byte must not matter
    if ($urandom_range(9) == 0) begin
      d1 = 8'(100 * $urandom_range(2));
      d2 = 8'(100 * $urandom_range(2));
    end
    h = live_cfg.header;
    v = live_cfg.version;
    f = live_cfg.footer;
    cs = frame_sum(c, d1, d2, d3);
    if (kind >= 92) begin
      {h, v, c, d1, d2, d3, cs, f} = {$urandom, $urandom};
    end else if (kind >= 88) begin
      v ^= 8'($urandom_range(1, 255));
      cs ^= 8'($urandom_range(1, 255));
    end else if (kind >= 80) begin
      cs ^= 8'($urandom_range(1, 255));
    end else if (kind >= 74) begin
      v ^= 8'($urandom_range(1, 255));
    end else if (kind >= 67) begin
      f ^= 8'($urandom_range(1, 255));
    end else if (kind >= 60) begin
      h ^= 8'($urandom_range(1, 255));
    end
    send_frame(h, v, c, d1, d2, d3, cs, f);
  endtask

  // stray bytes knock the framing out of step, then padding brings it back
  task automatic send_noise_burst();
    repeat ($urandom_range(1, 7)) send_byte(8'($urandom));
    send_random_frame();
    while (bytes_sent % FRAME_BYTES != 0) send_byte(8'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_HEADER: live_cfg.header = val;
      REG_VERSION: live_cfg.version = val;
      REG_FOOTER: live_cfg.footer = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] h, v, f);
    write_reg(REG_HEADER, h);
    write_reg(REG_VERSION, v);
    write_reg(REG_FOOTER, f);
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // largest positive and negative temperatures, then a frame failing every check
    send_frame(HEADER_RESET, VERSION_RESET, CMD_TEMP, 8'd199, 8'd99, SIGN_POSITIVE,
               frame_sum(CMD_TEMP, 8'd199, 8'd99, SIGN_POSITIVE), FOOTER_RESET);
    send_frame(HEADER_RESET, VERSION_RESET, CMD_TEMP, 8'd99, 8'd199, 8'h00,
               frame_sum(CMD_TEMP, 8'd99, 8'd199, 8'h00), FOOTER_RESET);
    send_frame(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    s_tvalid <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        1: set_config(8'h00, 8'h00, 8'h00);
        2: set_config(8'hFF, 8'hFF, 8'hFF);
        3: set_config(8'($urandom), 8'($urandom), 8'($urandom));
        4: begin
          set_config(8'($urandom), 8'($urandom), 8'($urandom));
          write_reg(REG_UNUSED, 8'($urandom));
        end
        5: set_config(HEADER_RESET, VERSION_RESET, FOOTER_RESET);
        default: ;
      endcase
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 59;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 59;
        end
        default: begin
          sender_idle_pct = 35;
          receiver_stall_pct = 35;
        end
      endcase
      for (int f = 0; f < 30; f++) begin
        if ($urandom_range(24) == 0) begin
          send_noise_burst();
        end else begin
          send_random_frame();
        end
      end
      s_tvalid <= 1'b0;
    end

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ffrc_pkg.sv
rtl/core/ffrc_framer.sv
rtl/core/ffrc_checker.sv
rtl/core/fixed_frame_receiver_checker.sv
verif/ffrc_result_checker.sv
verif/tb_fixed_frame_receiver_checker.sv
